>>> rtl/core/pti_pkg.sv
// ============================================================================
// pti_pkg: shared types and constants of the particle table integrator
// Holds the command and result codes, payload structs and register indexes.
// ============================================================================
package pti_pkg;

    localparam int TABLE_SIZE_DEF = 32;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_REPORT   = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Z = 2'd2;
    localparam logic [1:0] REG_LIMIT    = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic        [23:0] life_ms;
        logic signed [31:0] start_vel_x;
        logic signed [31:0] start_vel_y;
        logic signed [31:0] start_vel_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic        [15:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [4:0]  slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [23:0] life_left;
        logic               last;
    } result_t;

    // Clamp a 34-bit signed value into 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -34'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

>>> rtl/core/pti_stream_if.sv
// ============================================================================
// pti_stream_if: valid/ready channel
// Carries one payload of type payload_t per transfer.
// ============================================================================
interface pti_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/particle_table_integrator_top.sv
// ============================================================================
// particle_table_integrator_top: ordered particle table with time stepping
// Adds particles at the emitter and moves them under constant acceleration.
// ============================================================================
// Usage: items arrive on in_ch (valid/ready); results leave on out_ch, the
// final result of each item marked by last. The user must write registers
// (origin_x/y/z, particle_limit) over the APB port only while the block is
// idle; the block does not enforce this. An add gives one result, presented
// in the output state after the add state; the block takes the next item in
// the cycle after the result transfer. A tick walks the table once: dropped
// particles are read and skipped; a live one makes six passes through one
// shared four-step divider by 2000 (velocity then position per axis) and is
// written back; then each survivor is read back and reported in turn.
// in_ch.ready is high only in the idle state.
// Reset clears live count and origins, sets limit to 32; table memories stay.
// A stalled out_ch holds the current result and the sequencer waits on it.
// ============================================================================
module particle_table_integrator_top #(
    parameter int TABLE_SIZE = pti_pkg::TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pti_stream_if.sink   in_ch,
    pti_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_VDIV   = 4'd4;
    localparam logic [3:0] S_VWAIT  = 4'd5;
    localparam logic [3:0] S_PDIV   = 4'd6;
    localparam logic [3:0] S_PWAIT  = 4'd7;
    localparam logic [3:0] S_WB     = 4'd8;
    localparam logic [3:0] S_RPT_RD = 4'd9;
    localparam logic [3:0] S_RPT    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    // configuration registers
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic        [5:0]  limit_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            limit_reg <= 6'd32;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pti_pkg::REG_ORIGIN_X: org_x_reg <= pwdata;
                pti_pkg::REG_ORIGIN_Y: org_y_reg <= pwdata;
                pti_pkg::REG_ORIGIN_Z: org_z_reg <= pwdata;
                pti_pkg::REG_LIMIT:    limit_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            pti_pkg::REG_ORIGIN_X: prdata = org_x_reg;
            pti_pkg::REG_ORIGIN_Y: prdata = org_y_reg;
            pti_pkg::REG_ORIGIN_Z: prdata = org_z_reg;
            default:               prdata = {26'd0, limit_reg};
        endcase
    end

    // table memories: one row per particle, axes side by side
    logic [95:0] pos_mem [TABLE_SIZE];
    logic [95:0] vel_mem [TABLE_SIZE];
    logic [95:0] acc_mem [TABLE_SIZE];
    logic [23:0] life_mem [TABLE_SIZE];

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [95:0]   wr_pos, wr_vel, wr_acc;
    logic [23:0]   wr_life;
    logic [IW-1:0] rd_addr;
    logic [95:0]   rd_pos, rd_vel, rd_acc;
    logic [23:0]   rd_life;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr]  <= wr_pos;
            vel_mem[wr_addr]  <= wr_vel;
            acc_mem[wr_addr]  <= wr_acc;
            life_mem[wr_addr] <= wr_life;
        end
        rd_pos  <= pos_mem[rd_addr];
        rd_vel  <= vel_mem[rd_addr];
        rd_acc  <= acc_mem[rd_addr];
        rd_life <= life_mem[rd_addr];
    end

    // sequencer state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [1:0]    axis_reg, axis_next;
    logic          step_reg, step_next;
    pti_pkg::item_t   item_reg, item_next;
    pti_pkg::result_t res_reg, res_next;
    logic [95:0]   pos_reg, pos_next, vel_reg, vel_next, acc_reg, acc_next;
    logic [23:0]   life_reg, life_next;
    logic [31:0]   dsq_reg, dsq_next;
    logic [63:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;

    // shared divider
    logic        div_start, div_done;
    logic [63:0] div_quo;

    pti_divu u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [CW-1:0] cap;
    logic [5:0]    limit_ext;
    logic signed [31:0] cur_v, cur_a, cur_p, nv_cur;
    logic signed [32:0] vsum;
    logic [32:0]   vsum_mag;
    logic [31:0]   a_mag;
    logic signed [33:0] sum34;
    logic [15:0]   dly;

    assign limit_ext = limit_reg;
    assign cap = (32'(limit_ext) < TABLE_SIZE) ? CW'(limit_ext) : CW'(TABLE_SIZE);
    assign dly = item_reg.elapsed_ms;
    assign cur_v = vel_reg[32*axis_reg +: 32];
    assign cur_a = acc_reg[32*axis_reg +: 32];
    assign cur_p = pos_reg[32*axis_reg +: 32];
    assign nv_cur = res_reg.pos_x;  // holds new velocity between passes
    assign vsum = 33'(cur_v) + 33'(nv_cur);
    assign vsum_mag = vsum[32] ? 33'(-vsum) : 33'(vsum);
    assign a_mag = cur_a[31] ? 32'(-33'(cur_a)) : 32'(cur_a);

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        live_next  = live_reg;
        rd_next    = rd_reg;
        wp_next    = wp_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        acc_next   = acc_reg;
        life_next  = life_reg;
        dsq_next   = dsq_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        wr_en      = 1'b0;
        wr_addr    = wp_reg[IW-1:0];
        wr_pos     = pos_reg;
        wr_vel     = vel_reg;
        wr_acc     = acc_reg;
        wr_life    = life_reg;
        rd_addr    = rd_reg[IW-1:0];
        div_start  = 1'b0;
        sum34      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_ch.data;
                    rd_next   = '0;
                    wp_next   = '0;
                    dsq_next  = 32'(in_ch.data.elapsed_ms) * 32'(in_ch.data.elapsed_ms);
                    state_next = (in_ch.data.cmd == pti_pkg::CMD_ADD) ? S_ADD : S_RD;
                end
            end
            S_ADD:
            begin
                res_next = '0;
                res_next.last = 1'b1;
                if (live_reg >= cap)
                    res_next.kind = pti_pkg::KIND_ADD_FULL;
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = live_reg[IW-1:0];
                    wr_pos[31:0]  = pti_pkg::sat34(34'(org_x_reg) +
                                    34'({{18{item_reg.offset_x[15]}}, item_reg.offset_x} <<< 12));
                    wr_pos[63:32] = pti_pkg::sat34(34'(org_y_reg) +
                                    34'({{18{item_reg.offset_y[15]}}, item_reg.offset_y} <<< 12));
                    wr_pos[95:64] = org_z_reg;
                    wr_vel  = {item_reg.start_vel_z, item_reg.start_vel_y, item_reg.start_vel_x};
                    wr_acc  = {item_reg.accel_z, item_reg.accel_y, item_reg.accel_x};
                    wr_life = item_reg.life_ms;
                    res_next.kind  = pti_pkg::KIND_ADD_OK;
                    res_next.slot  = 5'(live_reg);
                    res_next.pos_x = wr_pos[31:0];
                    res_next.pos_y = wr_pos[63:32];
                    res_next.pos_z = wr_pos[95:64];
                    res_next.life_left = item_reg.life_ms;
                    live_next = live_reg + CW'(1);
                end
                step_next  = 1'b0;
                state_next = S_OUT;
            end
            S_RD:
            begin
                // walk reads one row; end of table moves to reporting, or to a none result
                if (rd_reg >= live_reg)
                begin
                    live_next = wp_reg;
                    rd_next   = '0;
                    if (wp_reg == '0)
                    begin
                        res_next = '0;
                        res_next.kind = pti_pkg::KIND_NONE;
                        res_next.last = 1'b1;
                        step_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_RPT_RD;
                end
                else
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                pos_next  = rd_pos;
                vel_next  = rd_vel;
                acc_next  = rd_acc;
                life_next = rd_life;
                axis_next = 2'd0;
                rd_next   = rd_reg + CW'(1);
                if ({8'd0, dly} >= rd_life)
                    state_next = S_RD;
                else
                begin
                    life_next  = 24'(rd_life - {8'd0, dly});
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                // |a| * d*d, divided by 2000
                mag_next   = 64'(a_mag) * 64'(dsq_reg);
                neg_next   = cur_a[31];
                step_next  = 1'b0;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (!step_next && !step_reg)
                begin
                    div_start = 1'b1;
                    step_next = 1'b1;
                end
                else if (div_done)
                begin
                    // a quotient of 2^32 or more saturates whatever the velocity
                    sum34 = 34'(cur_v) + (neg_reg ? -34'(div_quo[31:0]) : 34'(div_quo[31:0]));
                    if (div_quo[63:32] != '0)
                        sum34 = neg_reg ? -34'sd8589934591 : 34'sd8589934591;
                    res_next.pos_x = pti_pkg::sat34(sum34);
                    state_next = S_PDIV;
                end
            end
            S_PDIV:
            begin
                mag_next   = 64'(vsum_mag) * 64'(dly);
                neg_next   = vsum[32];
                step_next  = 1'b0;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!step_reg)
                begin
                    div_start = 1'b1;
                    step_next = 1'b1;
                end
                else if (div_done)
                begin
                    // a quotient of 2^32 or more saturates whatever the position
                    sum34 = 34'(cur_p) + (neg_reg ? -34'(div_quo[31:0]) : 34'(div_quo[31:0]));
                    if (div_quo[63:32] != '0)
                        sum34 = neg_reg ? -34'sd8589934591 : 34'sd8589934591;
                    pos_next[32*axis_reg +: 32] = pti_pkg::sat34(sum34);
                    vel_next[32*axis_reg +: 32] = nv_cur;
                    if (axis_reg == 2'd2)
                        state_next = S_WB;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_VDIV;
                    end
                end
            end
            S_WB:
            begin
                wr_en      = 1'b1;
                wp_next    = wp_reg + CW'(1);
                state_next = S_RD;
            end
            S_RPT_RD:
            begin
                state_next = S_RPT;
            end
            S_RPT:
            begin
                res_next.kind  = pti_pkg::KIND_REPORT;
                res_next.slot  = 5'(rd_reg);
                res_next.pos_x = rd_pos[31:0];
                res_next.pos_y = rd_pos[63:32];
                res_next.pos_z = rd_pos[95:64];
                res_next.life_left = rd_life;
                res_next.last  = (rd_reg + CW'(1) == live_reg);
                step_next  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (res_reg.last)
                        state_next = S_IDLE;
                    else
                    begin
                        rd_next    = rd_reg + CW'(1);
                        state_next = S_RPT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            rd_reg    <= '0;
            wp_reg    <= '0;
            axis_reg  <= '0;
            step_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            rd_reg    <= rd_next;
            wp_reg    <= wp_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        acc_reg  <= acc_next;
        life_reg <= life_next;
        dsq_reg  <= dsq_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
    end
endmodule

>>> rtl/core/pti_divu.sv
// ============================================================================
// pti_divu: unsigned divider by 2000
// Takes 16 dividend bits per cycle over a 64-bit dividend; each quotient digit
// comes from a shift by 4 and a reciprocal multiplication by 1/125.
// ============================================================================
module pti_divu
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient
);
    localparam logic [26:0] DIVISOR   = 27'd2000;
    // ceil(2^30 / 125), exact for every partial dividend below 2^23
    localparam logic [23:0] RECIP_125 = 24'd8589935;

    logic [63:0] quo_reg, quo_next;
    logic [10:0] rem_reg, rem_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [26:0] part;
    logic [45:0] prod;
    logic [15:0] digit;

    // Partial dividend stays below 2000 * 2^16, so each digit fits 16 bits
    assign part     = {rem_reg, quo_reg[63:48]};
    assign prod     = 46'(part[26:4]) * 46'(RECIP_125);
    assign digit    = 16'(prod >> 30);
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Shift in one 16-bit chunk per cycle and keep the running remainder
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[47:0], digit};
            rem_next = 11'(part - 27'(digit) * DIVISOR);
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
endmodule
